[rtl/core/rldd_pkg.sv]
// ----------------------------------------------------------------------------
// Redundant link drift diagnostics package
// Shared constants, payload structs and controller/datapath command types.
// ----------------------------------------------------------------------------
package rldd_pkg;

    localparam int RED_CHANNELS = 2;
    localparam int PATHS        = 2;
    localparam int WINDOW_DEPTH = 256;

    localparam int CH_W   = (RED_CHANNELS > 1) ? $clog2(RED_CHANNELS) : 1;
    localparam int PATH_W = (PATHS > 1) ? $clog2(PATHS) : 1;
    localparam int IDX_W  = $clog2(WINDOW_DEPTH);
    localparam int FILL_W = $clog2(WINDOW_DEPTH + 1);
    localparam int ADDR_W = CH_W + IDX_W;
    localparam int SLOT_W = CH_W + PATH_W;

    localparam logic [1:0] REG_WINDOW_SIZE = 2'd0;
    localparam logic [1:0] REG_MAX_DRIFT   = 2'd1;
    localparam logic [1:0] REG_PATH_COUNT  = 2'd2;

    localparam logic CMD_ARRIVAL = 1'b0;
    localparam logic CMD_CLEAR   = 1'b1;

    typedef struct packed {
        logic        command;
        logic        red_channel;
        logic        path_index;
        logic [31:0] seq_num;
        logic [31:0] time_stamp;
    } t_in_item;

    typedef struct packed {
        logic        report_channel;
        logic        report_path;
        logic [8:0]  window_count;
        logic [8:0]  missed_count;
        logic [31:0] drift_sum;
        logic [31:0] drift_square_sum;
        logic        last;
        logic        error;
    } t_out_item;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_SRCH_RD,
        OP_CMP,
        OP_MATCH,
        OP_SQR,
        OP_ACC,
        OP_CNT_RD,
        OP_CNT,
        OP_REPORT,
        OP_CLR,
        OP_APPEND
    } t_op;

    typedef struct packed {
        t_op              op;
        logic [IDX_W-1:0] idx;
        logic [PATH_W-1:0] path;
        logic             last;
    } t_cmd;

    typedef struct packed {
        logic             hit;
        logic             in_time;
        logic [FILL_W-1:0] fill;
    } t_stat;

endpackage

[rtl/core/redundant_link_drift_diagnostics.sv]
// ----------------------------------------------------------------------------
// Redundant link drift diagnostics
// Each searched window entry is read, compared and matched in turn; when a
// window closes, every path is counted and reported. One item at a time.
// Synchronous active-low reset clears fills, sums and config.
// ----------------------------------------------------------------------------
module redundant_link_drift_diagnostics
    import rldd_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_item  i_in_item,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out_item,
    input  logic      i_cfg_we,
    input  logic [1:0] i_cfg_index,
    input  logic [15:0] i_cfg_data
);

    logic [8:0]  r_window_size;
    logic [15:0] r_max_drift;
    logic [1:0]  r_path_count;
    t_cmd w_cmd;
    t_stat w_stat;
    t_out_item w_report;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window_size <= 9'd200;
            r_max_drift   <= 16'd50;
            r_path_count  <= 2'd2;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_WINDOW_SIZE: r_window_size <= i_cfg_data[8:0];
                REG_MAX_DRIFT:   r_max_drift   <= i_cfg_data;
                REG_PATH_COUNT:  r_path_count  <= i_cfg_data[1:0];
                default: ;
            endcase
        end
    end

    rldd_ctrl u_ctrl (
        .i_clk, .i_rst_n, .i_in_valid, .o_in_ready, .i_in_item,
        .o_out_valid, .i_out_ready, .o_out_item,
        .i_report(w_report), .i_window_size(r_window_size),
        .i_path_count(r_path_count), .i_stat(w_stat), .o_cmd(w_cmd)
    );

    rldd_datapath u_dp (
        .i_clk, .i_rst_n, .i_item(i_in_item), .i_max_drift(r_max_drift),
        .i_cmd(w_cmd), .o_stat(w_stat), .o_report(w_report)
    );

endmodule

[rtl/core/rldd_datapath.sv]
// ----------------------------------------------------------------------------
// Drift diagnostics datapath
// Window memories, flag store, per-path sums and counters.
// ----------------------------------------------------------------------------
module rldd_datapath
    import rldd_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_in_item  i_item,
    input  logic [15:0] i_max_drift,
    input  t_cmd      i_cmd,
    output t_stat     o_stat,
    output t_out_item o_report
);

    localparam int NE = RED_CHANNELS * WINDOW_DEPTH;
    localparam int NS = RED_CHANNELS * PATHS;

    logic [31:0] r_mem_seq [NE];
    logic [31:0] r_mem_time [NE];
    logic [PATHS-1:0] r_flags [NE];

    logic [31:0] r_sum [NS];
    logic [31:0] r_sq  [NS];
    logic [FILL_W-1:0] r_fill [RED_CHANNELS];

    t_in_item r_item;
    logic [31:0] r_rd_seq, r_rd_time, r_delay;
    logic [63:0] r_prod;
    logic [PATHS-1:0] r_rd_flags;
    logic [IDX_W-1:0] r_match_idx;
    logic r_hit, r_in_time;
    logic [FILL_W-1:0] r_missed;
    t_out_item r_report;

    logic [CH_W-1:0] w_ch;
    logic [ADDR_W-1:0] w_addr;
    logic [SLOT_W-1:0] w_slot;
    logic [31:0] w_delay;

    assign w_ch   = CH_W'(r_item.red_channel);
    assign w_addr = {w_ch, i_cmd.idx};
    assign w_slot = {w_ch, i_cmd.path};
    assign w_delay = r_item.time_stamp - r_rd_time;

    always_ff @(posedge i_clk) begin
        if (i_cmd.op == OP_SRCH_RD || i_cmd.op == OP_CNT_RD) begin
            r_rd_seq   <= r_mem_seq[w_addr];
            r_rd_time  <= r_mem_time[w_addr];
            r_rd_flags <= r_flags[w_addr];
        end
        if (i_cmd.op == OP_APPEND) begin
            r_mem_seq[w_addr]  <= r_item.seq_num;
            r_mem_time[w_addr] <= r_item.time_stamp;
        end
        if (i_cmd.op == OP_APPEND) begin
            r_flags[w_addr] <= PATHS'(1) << r_item.path_index;
        end else if (i_cmd.op == OP_MATCH && r_hit && r_in_time) begin
            r_flags[{w_ch, r_match_idx}] <= r_rd_flags |
                (PATHS'(1) << r_item.path_index);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hit <= 1'b0;
            r_in_time <= 1'b0;
            r_missed <= '0;
            for (int k = 0; k < NS; k++) begin
                r_sum[k] <= '0;
                r_sq[k]  <= '0;
            end
            for (int k = 0; k < RED_CHANNELS; k++) r_fill[k] <= '0;
        end else begin
            case (i_cmd.op)
                OP_LOAD: begin
                    r_hit <= 1'b0;
                    r_missed <= '0;
                end
                OP_CMP: begin
                    if (r_rd_seq == r_item.seq_num) begin
                        r_hit <= 1'b1;
                        r_match_idx <= i_cmd.idx;
                        r_delay <= w_delay;
                        r_in_time <= w_delay <= {16'd0, i_max_drift};
                    end
                end
                OP_SQR: r_prod <= r_delay * r_delay;
                OP_ACC: begin
                    if (r_in_time) begin
                        r_sum[{w_ch, PATH_W'(r_item.path_index)}] <=
                            r_sum[{w_ch, PATH_W'(r_item.path_index)}] + r_delay;
                        r_sq[{w_ch, PATH_W'(r_item.path_index)}] <=
                            r_sq[{w_ch, PATH_W'(r_item.path_index)}] + r_prod[31:0];
                    end
                end
                OP_CNT: begin
                    if (!r_rd_flags[i_cmd.path]) r_missed <= r_missed + 1'b1;
                end
                OP_REPORT: r_missed <= '0;
                OP_CLR: begin
                    r_fill[w_ch] <= '0;
                    for (int k = 0; k < PATHS; k++) begin
                        r_sum[{w_ch, PATH_W'(k)}] <= '0;
                        r_sq[{w_ch, PATH_W'(k)}]  <= '0;
                    end
                end
                OP_APPEND: begin
                    r_fill[w_ch] <= FILL_W'(i_cmd.idx) + 1'b1;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.op == OP_LOAD) r_item <= i_item;
        if (i_cmd.op == OP_REPORT) begin
            r_report.report_channel   <= r_item.red_channel;
            r_report.report_path      <= i_cmd.path[0];
            r_report.window_count     <= 9'(r_fill[w_ch]);
            r_report.missed_count     <= 9'(r_missed);
            r_report.drift_sum        <= r_sum[w_slot];
            r_report.drift_square_sum <= r_sq[w_slot];
            r_report.last             <= i_cmd.last;
            r_report.error            <= 1'b0;
        end
    end

    assign o_stat.hit     = r_hit;
    assign o_stat.in_time = r_in_time;
    assign o_stat.fill    = r_fill[w_ch];
    assign o_report       = r_report;

endmodule

[rtl/core/rldd_ctrl.sv]
// ----------------------------------------------------------------------------
// Drift diagnostics controller
// Sequences search, report scan, clear and append; owns both handshakes.
// ----------------------------------------------------------------------------
module rldd_ctrl
    import rldd_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_item  i_in_item,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out_item,
    input  t_out_item i_report,
    input  logic [8:0] i_window_size,
    input  logic [1:0] i_path_count,
    input  t_stat     i_stat,
    output t_cmd      o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE, S_START, S_SRCH_RD, S_SRCH_CMP, S_MATCH, S_SQR, S_ACC,
        S_CNT_RD, S_CNT, S_REPORT, S_SEND, S_CLR, S_APPEND, S_ERR
    } t_state;

    t_state r_state;
    t_in_item r_item;
    logic [FILL_W-1:0] r_i;
    logic [PATH_W-1:0] r_q;
    logic r_out_valid, r_err;
    logic [FILL_W-1:0] w_win;
    logic [PATH_W:0] w_paths;
    logic [FILL_W-1:0] w_fill;

    always_comb begin
        if (i_window_size == 9'd0) w_win = FILL_W'(1);
        else if ({{(FILL_W > 9 ? FILL_W - 9 : 0){1'b0}}, i_window_size} > WINDOW_DEPTH)
            w_win = FILL_W'(WINDOW_DEPTH);
        else w_win = FILL_W'(i_window_size);
        if (i_path_count == 2'd0) w_paths = (PATH_W + 1)'(1);
        else if (i_path_count > PATHS) w_paths = (PATH_W + 1)'(PATHS);
        else w_paths = (PATH_W + 1)'(i_path_count);
    end

    assign w_fill = i_stat.fill;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_out_valid <= 1'b0;
            r_err <= 1'b0;
            r_i <= '0;
            r_q <= '0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_item <= i_in_item;
                        if (32'(i_in_item.red_channel) >= RED_CHANNELS ||
                            (i_in_item.command == CMD_ARRIVAL &&
                             (PATH_W + 1)'(i_in_item.path_index) >= w_paths)) begin
                            r_err <= 1'b1;
                            r_out_valid <= 1'b1;
                            r_state <= S_SEND;
                        end else begin
                            r_state <= S_START;
                        end
                    end
                end
                S_START: begin
                    r_i <= w_fill;
                    r_q <= '0;
                    if (r_item.command == CMD_CLEAR) r_state <= S_CLR;
                    else if (w_fill == '0) r_state <= S_APPEND;
                    else r_state <= S_SRCH_RD;
                end
                S_SRCH_RD: r_state <= S_SRCH_CMP;
                S_SRCH_CMP: begin
                    r_i <= r_i - 1'b1;
                    r_state <= S_MATCH;
                end
                S_MATCH: begin
                    if (i_stat.hit) r_state <= i_stat.in_time ? S_SQR : S_IDLE;
                    else if (r_i != '0) r_state <= S_SRCH_RD;
                    else if (w_fill >= w_win) begin
                        r_i <= '0;
                        r_state <= S_CNT_RD;
                    end else begin
                        r_i <= w_fill;
                        r_state <= S_APPEND;
                    end
                end
                S_SQR: r_state <= S_ACC;
                S_ACC: r_state <= S_IDLE;
                S_CNT_RD: r_state <= S_CNT;
                S_CNT: begin
                    r_i <= r_i + 1'b1;
                    r_state <= (r_i + 1'b1 == w_fill) ? S_REPORT : S_CNT_RD;
                end
                S_REPORT: begin
                    r_out_valid <= 1'b1;
                    r_err <= 1'b0;
                    r_state <= S_SEND;
                end
                S_SEND: begin
                    if (i_out_ready) begin
                        r_out_valid <= 1'b0;
                        if (r_err) begin
                            r_err <= 1'b0;
                            r_state <= S_IDLE;
                        end else if ((PATH_W + 1)'(r_q) + 1'b1 == w_paths) begin
                            r_state <= S_CLR;
                        end else begin
                            r_q <= r_q + 1'b1;
                            r_i <= '0;
                            r_state <= S_CNT_RD;
                        end
                    end
                end
                S_CLR: begin
                    r_i <= '0;
                    r_state <= (r_item.command == CMD_CLEAR) ? S_IDLE : S_APPEND;
                end
                S_APPEND: r_state <= S_IDLE;
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

    always_comb begin
        o_out_item = i_report;
        if (r_err) begin
            o_out_item = '0;
            o_out_item.report_channel = r_item.red_channel;
            o_out_item.report_path    = r_item.path_index;
            o_out_item.last  = 1'b1;
            o_out_item.error = 1'b1;
        end
    end

    always_comb begin
        o_cmd.op   = OP_NONE;
        o_cmd.idx  = r_i[IDX_W-1:0];
        o_cmd.path = r_q;
        o_cmd.last = ((PATH_W + 1)'(r_q) + 1'b1 == w_paths);
        case (r_state)
            S_IDLE:     if (i_in_valid) o_cmd.op = OP_LOAD;
            S_SRCH_RD:  begin
                o_cmd.op = OP_SRCH_RD;
                o_cmd.idx = IDX_W'(r_i - 1'b1);
            end
            S_SRCH_CMP: begin
                o_cmd.op = OP_CMP;
                o_cmd.idx = IDX_W'(r_i - 1'b1);
            end
            S_MATCH:    o_cmd.op = OP_MATCH;
            S_SQR:      o_cmd.op = OP_SQR;
            S_ACC:      o_cmd.op = OP_ACC;
            S_CNT_RD:   o_cmd.op = OP_CNT_RD;
            S_CNT:      o_cmd.op = OP_CNT;
            S_REPORT:   o_cmd.op = OP_REPORT;
            S_CLR:      o_cmd.op = OP_CLR;
            S_APPEND:   o_cmd.op = OP_APPEND;
            default:    o_cmd.op = OP_NONE;
        endcase
    end

    a_ready_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_ready |-> !o_out_valid)
        else $error("ready while a result is pending");
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("result dropped before accept");
    a_err_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.error |-> o_out_item.last)
        else $error("error result without last");

endmodule

[test/rldd_checker.sv]
// ----------------------------------------------------------------------------
// Redundant link drift diagnostics checker
// Watches the config port and both channels, predicts the report beats of
// every accepted input beat from its own copy of the windows and sums, and
// compares each output beat, field by field, with the oldest prediction.
// ----------------------------------------------------------------------------
module rldd_checker
    import rldd_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic       i_in_ready,
    input  t_in_item   i_in_item,
    input  logic       i_out_valid,
    input  logic       i_out_ready,
    input  t_out_item  i_out_item,
    input  logic       i_cfg_we,
    input  logic [1:0] i_cfg_index,
    input  logic [15:0] i_cfg_data,
    output int         o_fail_count,
    output int         o_pending,
    output int         o_checked
);

    logic [8:0]  win_size_q;
    logic [15:0] max_drift_q;
    logic [1:0]  path_count_q;

    int          fill_q   [RED_CHANNELS];
    logic [31:0] seq_mem  [RED_CHANNELS][WINDOW_DEPTH];
    logic [31:0] stamp_mem[RED_CHANNELS][WINDOW_DEPTH];
    logic [1:0]  seen_mem [RED_CHANNELS][WINDOW_DEPTH];
    logic [31:0] dsum_q   [RED_CHANNELS][PATHS];
    logic [31:0] dsq_q    [RED_CHANNELS][PATHS];

    t_out_item   report_q[$];

    assign o_pending = report_q.size();

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("MISMATCH at %0t: %s got %0h expected %0h", $realtime, what, got, want);
        o_fail_count++;
    endtask

    task automatic clear_window(int ch);
        fill_q[ch] = 0;
        for (int i = 0; i < WINDOW_DEPTH; i++) begin
            seen_mem[ch][i] = '0;
        end
        for (int p = 0; p < PATHS; p++) begin
            dsum_q[ch][p] = '0;
            dsq_q[ch][p]  = '0;
        end
    endtask

    task automatic predict_reports(t_in_item it);
        int          paths;
        int          win;
        int          ch;
        int          p;
        int          f;
        int          miss;
        logic [31:0] d;
        logic [63:0] sq;
        t_out_item   r;
        paths = (path_count_q == 0) ? 1 : (path_count_q > PATHS) ? PATHS : path_count_q;
        win   = (win_size_q == 0) ? 1 : (win_size_q > WINDOW_DEPTH) ? WINDOW_DEPTH : win_size_q;
        ch    = it.red_channel;
        p     = it.path_index;
        if (it.command == CMD_ARRIVAL && p >= paths) begin
            r = '0;
            r.report_channel = it.red_channel;
            r.report_path    = it.path_index;
            r.last           = 1'b1;
            r.error          = 1'b1;
            report_q.push_back(r);
            return;
        end
        if (it.command == CMD_CLEAR) begin
            clear_window(ch);
            return;
        end
        f = fill_q[ch];
        for (int i = f - 1; i >= 0; i--) begin
            if (seq_mem[ch][i] == it.seq_num) begin
                d = it.time_stamp - stamp_mem[ch][i];
                if (d <= {16'd0, max_drift_q}) begin
                    sq = {32'd0, d} * {32'd0, d};
                    dsum_q[ch][p]    = dsum_q[ch][p] + d;
                    dsq_q[ch][p]     = dsq_q[ch][p] + sq[31:0];
                    seen_mem[ch][i][p] = 1'b1;
                end
                return;
            end
        end
        if (f >= win) begin
            for (int q = 0; q < paths; q++) begin
                miss = 0;
                for (int i = 0; i < f; i++) begin
                    if (!seen_mem[ch][i][q]) miss++;
                end
                r = '0;
                r.report_channel   = it.red_channel;
                r.report_path      = q[0];
                r.window_count     = f[8:0];
                r.missed_count     = miss[8:0];
                r.drift_sum        = dsum_q[ch][q];
                r.drift_square_sum = dsq_q[ch][q];
                r.last             = (q + 1 == paths);
                report_q.push_back(r);
            end
            clear_window(ch);
            f = 0;
        end
        seq_mem[ch][f]   = it.seq_num;
        stamp_mem[ch][f] = it.time_stamp;
        seen_mem[ch][f]  = '0;
        seen_mem[ch][f][p] = 1'b1;
        fill_q[ch] = f + 1;
    endtask

    task automatic check_report(t_out_item got);
        t_out_item want;
        if (report_q.size() == 0) begin
            report_mismatch("unexpected report beat", 32'd1, 32'd0);
            return;
        end
        want = report_q.pop_front();
        o_checked++;
        if (got.report_channel != want.report_channel)
            report_mismatch("report_channel", got.report_channel, want.report_channel);
        if (got.report_path != want.report_path)
            report_mismatch("report_path", got.report_path, want.report_path);
        if (got.window_count != want.window_count)
            report_mismatch("window_count", got.window_count, want.window_count);
        if (got.missed_count != want.missed_count)
            report_mismatch("missed_count", got.missed_count, want.missed_count);
        if (got.drift_sum != want.drift_sum)
            report_mismatch("drift_sum", got.drift_sum, want.drift_sum);
        if (got.drift_square_sum != want.drift_square_sum)
            report_mismatch("drift_square_sum", got.drift_square_sum, want.drift_square_sum);
        if (got.last != want.last)
            report_mismatch("last", got.last, want.last);
        if (got.error != want.error)
            report_mismatch("error", got.error, want.error);
    endtask

    initial begin
        o_fail_count = 0;
        o_checked    = 0;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            win_size_q   = 9'd200;
            max_drift_q  = 16'd50;
            path_count_q = 2'd2;
            for (int c = 0; c < RED_CHANNELS; c++) begin
                clear_window(c);
            end
            report_q.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    REG_WINDOW_SIZE: win_size_q   = i_cfg_data[8:0];
                    REG_MAX_DRIFT:   max_drift_q  = i_cfg_data;
                    REG_PATH_COUNT:  path_count_q = i_cfg_data[1:0];
                    default: ;
                endcase
            end
            if (i_in_valid && i_in_ready) predict_reports(i_in_item);
            if (i_out_valid && i_out_ready) check_report(i_out_item);
        end
    end

endmodule

[test/tb_redundant_link_drift_diagnostics.sv]
// ----------------------------------------------------------------------------
// Redundant link drift diagnostics testbench
// Drives directed and random arrival and clear beats through several register
// settings with random idling on both sides and one long output stall; the
// checker instance predicts and compares every report beat.
// ----------------------------------------------------------------------------
module tb_redundant_link_drift_diagnostics;
    import rldd_pkg::*;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    t_in_item    in_item;
    logic        out_valid;
    logic        out_ready;
    t_out_item   out_item;
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [15:0] cfg_data;

    int          fail_count;
    int          pending;
    int          checked;
    int          beats_sent;
    bit          no_idle;
    bit          hold_off_req;
    logic [15:0] cur_drift;

    logic [31:0] next_seq [RED_CHANNELS];
    logic [31:0] now_ms   [RED_CHANNELS];
    logic [31:0] ring_seq [RED_CHANNELS][8];
    logic [31:0] ring_ms  [RED_CHANNELS][8];
    int          ring_ptr [RED_CHANNELS];

    redundant_link_drift_diagnostics u_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_item  (out_item),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    rldd_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_ready   (in_ready),
        .i_in_item    (in_item),
        .i_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .i_out_item   (out_item),
        .i_cfg_we     (cfg_we),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_checked    (checked)
    );

    initial clk = 1'b0;
    always #6 clk = ~clk;

    initial begin
        #(12 * 8000000);
        $display("tb_redundant_link_drift_diagnostics failed");
        $finish;
    end

    initial begin
        out_ready = 1'b0;
        forever begin
            @(negedge clk);
            if (hold_off_req) begin
                out_ready = 1'b0;
                repeat (400) @(negedge clk);
                hold_off_req = 1'b0;
            end else if (!no_idle && $urandom_range(0, 3) == 0) begin
                out_ready = 1'b0;
                repeat ($urandom_range(1, 5) - 1) @(negedge clk);
            end else begin
                out_ready = 1'b1;
            end
        end
    end

    task automatic send_beat(logic cmd, logic ch, logic path, logic [31:0] seq,
                             logic [31:0] ms);
        if (!no_idle && $urandom_range(0, 3) == 0) begin
            in_valid = 1'b0;
            repeat ($urandom_range(1, 5)) @(negedge clk);
        end
        in_valid                = 1'b1;
        in_item.command         = cmd;
        in_item.red_channel     = ch;
        in_item.path_index      = path;
        in_item.seq_num         = seq;
        in_item.time_stamp      = ms;
        while (!in_ready) @(negedge clk);
        @(negedge clk);
        beats_sent++;
        in_valid = 1'b0;
    endtask

    task automatic write_reg(logic [1:0] idx, logic [15:0] val);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_data  = val;
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    task automatic settle_and_configure(logic [15:0] win, logic [15:0] drift,
                                        logic [15:0] paths);
        while (pending != 0) @(negedge clk);
        repeat (1700) @(negedge clk);
        write_reg(REG_WINDOW_SIZE, win);
        write_reg(REG_MAX_DRIFT, drift);
        write_reg(REG_PATH_COUNT, paths);
        cur_drift = drift;
    endtask

    task automatic random_beats(int count, int new_pct);
        int          r;
        int          k;
        logic        ch;
        logic [31:0] span;
        for (int n = 0; n < count; n++) begin
            r  = $urandom_range(0, 99);
            ch = 1'($urandom_range(0, 1));
            if (r < 3) begin
                send_beat(CMD_CLEAR, ch, 1'($urandom), $urandom, $urandom);
            end else if (r < 8) begin
                send_beat(1'($urandom), ch, 1'($urandom), $urandom, $urandom);
            end else if (r < 8 + new_pct) begin
                now_ms[ch] = now_ms[ch] + $urandom_range(0, 3);
                ring_seq[ch][ring_ptr[ch]] = next_seq[ch];
                ring_ms[ch][ring_ptr[ch]]  = now_ms[ch];
                ring_ptr[ch] = (ring_ptr[ch] + 1) % 8;
                send_beat(CMD_ARRIVAL, ch, 1'($urandom), next_seq[ch], now_ms[ch]);
                next_seq[ch]++;
            end else begin
                k    = $urandom_range(0, 7);
                span = {16'd0, cur_drift} + cur_drift / 4 + 2;
                send_beat(CMD_ARRIVAL, ch, 1'($urandom), ring_seq[ch][k],
                          ring_ms[ch][k] + $urandom_range(0, span));
            end
        end
    endtask

    initial begin
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        in_item      = '0;
        cfg_we       = 1'b0;
        cfg_index    = REG_WINDOW_SIZE;
        cfg_data     = '0;
        no_idle      = 1'b0;
        hold_off_req = 1'b0;
        beats_sent   = 0;
        cur_drift    = 16'd50;
        for (int c = 0; c < RED_CHANNELS; c++) begin
            next_seq[c] = $urandom;
            now_ms[c]   = $urandom;
            ring_ptr[c] = 0;
            for (int k = 0; k < 8; k++) begin
                ring_seq[c][k] = next_seq[c];
                ring_ms[c][k]  = now_ms[c];
            end
        end
        repeat (2) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Reset settings: exact drift limit, one late copy, timer wrap, clear.
        send_beat(CMD_ARRIVAL, 1'b0, 1'b0, 32'd0, 32'd0);
        send_beat(CMD_ARRIVAL, 1'b0, 1'b1, 32'd0, 32'd50);
        send_beat(CMD_ARRIVAL, 1'b0, 1'b1, 32'd0, 32'd51);
        send_beat(CMD_ARRIVAL, 1'b1, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFF0);
        send_beat(CMD_ARRIVAL, 1'b1, 1'b0, 32'hFFFF_FFFF, 32'h0000_0020);
        send_beat(CMD_ARRIVAL, 1'b1, 1'b0, 32'hFFFF_FFFF, 32'h0000_0021);
        send_beat(CMD_CLEAR, 1'b1, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_beat(CMD_ARRIVAL, 1'b1, 1'b0, 32'd5, 32'd1000);

        // Window size zero acts as one, widest drift, single path.
        settle_and_configure(16'd0, 16'hFFFF, 16'd1);
        send_beat(CMD_ARRIVAL, 1'b0, 1'b1, 32'd1, 32'd0);
        send_beat(CMD_ARRIVAL, 1'b0, 1'b0, 32'd1, 32'd0);
        send_beat(CMD_ARRIVAL, 1'b0, 1'b0, 32'd2, 32'd3);
        send_beat(CMD_ARRIVAL, 1'b1, 1'b0, 32'd7, 32'd100);
        send_beat(CMD_ARRIVAL, 1'b1, 1'b0, 32'd7, 32'd100 + 32'hFFFF);
        send_beat(CMD_ARRIVAL, 1'b1, 1'b0, 32'd8, 32'd0);
        random_beats(60, 40);

        // Zero drift, path count above range; long output stall at the start.
        settle_and_configure(16'd4, 16'd0, 16'd3);
        hold_off_req = 1'b1;
        random_beats(100, 45);

        // Largest window through an oversized setting.
        settle_and_configure(16'd511, 16'd50, 16'd2);
        random_beats(250, 45);

        // Window lowered below the current fill, path count zero.
        settle_and_configure(16'd2, 16'd10, 16'd0);
        random_beats(80, 40);

        settle_and_configure(16'd8, 16'd20, 16'd2);
        no_idle = 1'b1;
        random_beats(80, 40);

        while (pending != 0) @(negedge clk);
        repeat (2000) @(negedge clk);
        $display("Run covered %0d input beats over six register settings, %0d reports checked.",
                 beats_sent, checked);
        if (fail_count == 0) begin
            $display("tb_redundant_link_drift_diagnostics passed");
        end else begin
            $display("tb_redundant_link_drift_diagnostics failed");
        end
        $finish;
    end

endmodule

[filelist.f]
rtl/core/rldd_pkg.sv
rtl/core/rldd_datapath.sv
rtl/core/rldd_ctrl.sv
rtl/core/redundant_link_drift_diagnostics.sv
test/rldd_checker.sv
test/tb_redundant_link_drift_diagnostics.sv
